### rtl/bvma_pkg.sv
// battery voltage moving average: shared types and constants
// no dependencies; imported by the filter top level and its checker
package bvma_pkg;

    localparam int MV_W       = 16;
    localparam int OFFSET_W   = 10;
    localparam int PERIOD_W   = 16;
    localparam int PCOUNT_W   = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET         = 10'd60;
    localparam logic [PERIOD_W-1:0] BUFFER_PERIOD_RESET  = 16'd100;
    localparam logic [PERIOD_W-1:0] AVERAGE_PERIOD_RESET = 16'd1000;

    typedef enum logic [2:0] {
        CMD_SAMPLE      = 3'd0,
        CMD_BUFFER_TICK = 3'd1,
        CMD_PERIOD_TICK = 3'd2,
        CMD_SCAN        = 3'd3,
        CMD_RELEASE     = 3'd4
    } cmd_e_t;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_OFFSET         = 2'd0,
        REG_BUFFER_PERIOD  = 2'd1,
        REG_AVERAGE_PERIOD = 2'd2
    } cfg_idx_t;

    // work a request hands to the second stage
    typedef struct packed {
        logic fill;
        logic push;
        logic scan;
    } ring_op_t;

endpackage

### rtl/battery_voltage_moving_average.sv
// Battery voltage smoother: one command per cycle, sustained while the output is not stalled.
// Requests go through two stages: the first decodes the command and updates the tick
// counters, hold, latest reading and write slot, and issues the read of the ring memory
// entry about to be replaced; the second, from the registers loaded at acceptance, applies
// the ring write, the running-sum update and the average (on a scan, one constant-reciprocal
// multiply of the sum). out_valid rises when the second stage hands its result to the output
// register; a waiting result sits in the output register while the next request is taken.
// The ring memory needs no clearing pass: per-entry valid bits make unwritten entries read as
// the fill value (zero after reset, the first compensated sample afterwards).
module battery_voltage_moving_average
    import bvma_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            command,
    input  logic [MV_W-1:0]       sample_mv,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MV_W-1:0]       average_mv,
    output logic [MV_W-1:0]       latest_mv,
    output logic                  average_updated,
    output logic                  holding
);

    localparam int DEPTH_LOG = $clog2(HISTORY_DEPTH);
    localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? DEPTH_LOG : 1;
    localparam int SUM_W     = MV_W + DEPTH_LOG;
    localparam int RECIP_SH  = SUM_W + DEPTH_LOG;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    // ceil(2^RECIP_SH / depth): exact quotient for every sum below 2^SUM_W
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SH)
        + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(HISTORY_DEPTH);

    // configuration
    logic [OFFSET_W-1:0] offset_reg;
    logic [PERIOD_W-1:0] buffer_period_reg;
    logic [PERIOD_W-1:0] average_period_reg;
    logic                cfg_write;
    cfg_idx_t            cfg_idx;

    // first stage state
    logic [MV_W-1:0]          latest_reg, latest_next;
    logic                     init_reg, init_next;
    logic                     hold_reg, hold_next;
    logic [PERIOD_W-1:0]      buf_cnt_reg, buf_cnt_next;
    logic [PCOUNT_W-1:0]      per_cnt_reg, per_cnt_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [MV_W-1:0]          fill_val_reg;
    logic [HISTORY_DEPTH-1:0] ent_valid_reg;

    // second stage
    logic                b_valid_reg;
    ring_op_t            b_op_reg;
    logic [MV_W-1:0]     b_value_reg;
    logic [SLOT_W-1:0]   b_slot_reg;
    logic [MV_W-1:0]     b_latest_reg;
    logic                b_hold_reg;
    logic [MV_W-1:0]     mem_q_reg;
    logic                rd_use_mem_reg;
    logic [MV_W-1:0]     rd_alt_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [MV_W-1:0]     avg_reg, avg_next;

    // output register
    logic                out_valid_reg;
    logic [MV_W-1:0]     out_avg_reg;
    logic [MV_W-1:0]     out_latest_reg;
    logic                out_upd_reg;
    logic                out_hold_reg;

    logic [MV_W-1:0]     ring_mem [HISTORY_DEPTH];

    logic                accept;
    logic                out_free;
    logic                b_leave;
    logic                rd_fwd;
    ring_op_t            a_op;
    logic [MV_W-1:0]     a_value;
    logic [MV_W-1:0]     comp_mv;
    logic [PERIOD_W-1:0] buf_inc;
    logic [MV_W-1:0]     old_entry;
    logic [SUM_W:0]      push_sum;
    logic [PROD_W-1:0]   prod;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = cfg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg         <= OFFSET_RESET;
            buffer_period_reg  <= BUFFER_PERIOD_RESET;
            average_period_reg <= AVERAGE_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_OFFSET:         offset_reg         <= pwdata[OFFSET_W-1:0];
                REG_BUFFER_PERIOD:  buffer_period_reg  <= pwdata[PERIOD_W-1:0];
                REG_AVERAGE_PERIOD: average_period_reg <= pwdata[PERIOD_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OFFSET:         prdata = CFG_DATA_W'(offset_reg);
            REG_BUFFER_PERIOD:  prdata = CFG_DATA_W'(buffer_period_reg);
            REG_AVERAGE_PERIOD: prdata = CFG_DATA_W'(average_period_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign out_free = !out_valid_reg || !out_stall;
    assign b_leave  = b_valid_reg && out_free;
    assign in_stall = b_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // ---------------- first stage ----------------
    assign comp_mv = (sample_mv > MV_W'(offset_reg)) ? (sample_mv - MV_W'(offset_reg))
                                                     : sample_mv;
    assign buf_inc = buf_cnt_reg + PERIOD_W'(1);

    always_comb
    begin
        latest_next  = latest_reg;
        init_next    = init_reg;
        hold_next    = hold_reg;
        buf_cnt_next = buf_cnt_reg;
        per_cnt_next = per_cnt_reg;
        slot_next    = slot_reg;
        a_op         = '0;
        a_value      = '0;
        unique case (cmd_e_t'(command))
            CMD_SAMPLE:
            begin
                latest_next = comp_mv;
                if (!init_reg)
                begin
                    init_next = 1'b1;
                    hold_next = 1'b1;
                    slot_next = '0;
                    a_op.fill = 1'b1;
                    a_value   = comp_mv;
                end
            end
            CMD_BUFFER_TICK:
            begin
                if (buf_inc >= buffer_period_reg)
                begin
                    buf_cnt_next = '0;
                    a_op.push    = 1'b1;
                    a_value      = latest_reg;
                    slot_next    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                end
                else
                begin
                    buf_cnt_next = buf_inc;
                end
            end
            CMD_PERIOD_TICK:
            begin
                if (per_cnt_reg != '1)
                begin
                    per_cnt_next = per_cnt_reg + PCOUNT_W'(1);
                end
            end
            CMD_SCAN:
            begin
                if (latest_reg != '0 && !hold_reg
                    && per_cnt_reg >= PCOUNT_W'(average_period_reg))
                begin
                    per_cnt_next = '0;
                    a_op.scan    = 1'b1;
                end
            end
            CMD_RELEASE:
            begin
                hold_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg   <= '0;
            init_reg     <= 1'b0;
            hold_reg     <= 1'b0;
            buf_cnt_reg  <= '0;
            per_cnt_reg  <= '0;
            slot_reg     <= '0;
            fill_val_reg <= '0;
        end
        else if (accept)
        begin
            latest_reg  <= latest_next;
            init_reg    <= init_next;
            hold_reg    <= hold_next;
            buf_cnt_reg <= buf_cnt_next;
            per_cnt_reg <= per_cnt_next;
            slot_reg    <= slot_next;
            if (a_op.fill)
            begin
                fill_val_reg <= a_value;
            end
        end
    end

    // a fill from the new request overrides a write retiring in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
        end
        else
        begin
            if (accept && a_op.fill)
            begin
                ent_valid_reg <= '0;
            end
            else if (b_leave && b_op_reg.push)
            begin
                ent_valid_reg[b_slot_reg] <= 1'b1;
            end
        end
    end

    // ---------------- ring memory ----------------
    // same entry written by the retiring push: take its data instead of the memory
    assign rd_fwd = b_leave && b_op_reg.push && (b_slot_reg == slot_reg);

    always_ff @(posedge clk)
    begin
        if (b_leave && b_op_reg.push)
        begin
            ring_mem[b_slot_reg] <= b_value_reg;
        end
        if (accept && a_op.push)
        begin
            mem_q_reg      <= ring_mem[slot_reg];
            rd_use_mem_reg <= ent_valid_reg[slot_reg] && !rd_fwd;
            rd_alt_reg     <= rd_fwd ? b_value_reg : fill_val_reg;
        end
    end

    // ---------------- second stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_leave)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_op_reg     <= a_op;
            b_value_reg  <= a_value;
            b_slot_reg   <= slot_reg;
            b_latest_reg <= latest_next;
            b_hold_reg   <= hold_next;
        end
    end

    assign old_entry = rd_use_mem_reg ? mem_q_reg : rd_alt_reg;
    assign push_sum  = {1'b0, sum_reg} - (SUM_W + 1)'(old_entry) + (SUM_W + 1)'(b_value_reg);
    assign prod      = PROD_W'(sum_reg) * PROD_W'(RECIP);

    always_comb
    begin
        sum_next = sum_reg;
        avg_next = avg_reg;
        if (b_op_reg.fill)
        begin
            sum_next = SUM_W'(b_value_reg) * DEPTH_SUM;
            avg_next = b_value_reg;
        end
        if (b_op_reg.push)
        begin
            sum_next = push_sum[SUM_W-1:0];
        end
        if (b_op_reg.scan)
        begin
            avg_next = prod[RECIP_SH +: MV_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            avg_reg <= '0;
        end
        else if (b_leave)
        begin
            sum_reg <= sum_next;
            avg_reg <= avg_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= b_leave || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_leave)
        begin
            out_avg_reg    <= avg_next;
            out_latest_reg <= b_latest_reg;
            out_upd_reg    <= b_op_reg.fill || b_op_reg.scan;
            out_hold_reg   <= b_hold_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign average_mv      = out_avg_reg;
    assign latest_mv       = out_latest_reg;
    assign average_updated = out_upd_reg;
    assign holding         = out_hold_reg;

endmodule

### rtl/bvma_checker.sv
// port-level checks for the battery voltage moving average filter
// depends on bvma_pkg; bound to the top level at the end of this file
module bvma_checker
    import bvma_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input logic [MV_W-1:0] average_mv,
    input logic [MV_W-1:0] latest_mv,
    input logic            average_updated,
    input logic            holding
);

    logic out_take;
    logic hold_seen_reg, hold_seen_next;
    logic hold_done_reg, hold_done_next;

    assign out_take       = out_valid && !out_stall;
    assign hold_seen_next = hold_seen_reg || (out_take && holding);
    assign hold_done_next = hold_done_reg || (out_take && !holding && hold_seen_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen_reg <= 1'b0;
            hold_done_reg <= 1'b0;
        end
        else
        begin
            hold_seen_reg <= hold_seen_next;
            hold_done_reg <= hold_done_next;
        end
    end

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(average_mv) && $stable(latest_mv)
            && $stable(average_updated) && $stable(holding))
        else $error("result changed while stalled");

    // input only backs up when a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    // once released, the settle hold never comes back
    a_hold_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold_done_reg |-> !holding)
        else $error("settle hold raised again after release");

    // only the first sample can update the average under hold
    a_hold_update: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && average_updated && holding |-> !hold_seen_reg)
        else $error("average updated while hold raised");

    // a scan never recomputes with a zero latest reading
    a_zero_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && average_updated && latest_mv == '0 |-> holding)
        else $error("average recomputed with zero latest reading");

endmodule

bind battery_voltage_moving_average bvma_checker u_bvma_checker (.*);

### sim/tb_battery_voltage_moving_average.sv
// testbench for battery_voltage_moving_average: directed and random commands,
// results checked against an in-bench model of the ring average
// depends on rtl/bvma_pkg.sv and rtl/battery_voltage_moving_average.sv
module tb_battery_voltage_moving_average;
    import bvma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_CODE = 3'd7;

    typedef struct packed {
        logic [MV_W-1:0] average_mv;
        logic [MV_W-1:0] latest_mv;
        logic            average_updated;
        logic            holding;
    } readout_t;

    class voltage_average_predictor;
        logic [OFFSET_W-1:0] offset;
        logic [PERIOD_W-1:0] buffer_period;
        logic [PERIOD_W-1:0] average_period;
        logic [MV_W-1:0]     ring [RING_DEPTH];
        int unsigned         slot;
        logic [18:0]         ring_total;
        logic [PERIOD_W-1:0] buffer_ticks;
        logic [PCOUNT_W-1:0] period_ticks;
        logic [MV_W-1:0]     latest;
        logic [MV_W-1:0]     average;
        bit                  seeded;
        bit                  hold;
        readout_t            expected_readouts [$];
        int                  mismatches;

        function new();
            offset = OFFSET_RESET;
            buffer_period = BUFFER_PERIOD_RESET;
            average_period = AVERAGE_PERIOD_RESET;
            foreach (ring[i])
                ring[i] = '0;
            slot = 0;
            ring_total = '0;
            buffer_ticks = '0;
            period_ticks = '0;
            latest = '0;
            average = '0;
            seeded = 0;
            hold = 0;
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: mismatch: %s", $realtime, msg);
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_OFFSET:         offset = value[OFFSET_W-1:0];
                REG_BUFFER_PERIOD:  buffer_period = value[PERIOD_W-1:0];
                REG_AVERAGE_PERIOD: average_period = value[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_command(logic [2:0] cmd, logic [MV_W-1:0] mv);
            readout_t r;
            logic     updated;
            updated = 1'b0;
            case (cmd)
                CMD_SAMPLE:
                begin
                    if (mv > MV_W'(offset))
                        mv = mv - MV_W'(offset);
                    latest = mv;
                    if (!seeded)
                    begin
                        // first reading seeds the whole ring and the average
                        seeded = 1;
                        average = mv;
                        foreach (ring[i])
                            ring[i] = mv;
                        slot = 0;
                        ring_total = 19'(mv) * 19'(RING_DEPTH);
                        hold = 1;
                        updated = 1'b1;
                    end
                end
                CMD_BUFFER_TICK:
                begin
                    buffer_ticks = buffer_ticks + 1'b1;
                    if (buffer_ticks >= buffer_period)
                    begin
                        buffer_ticks = '0;
                        ring_total = ring_total - 19'(ring[slot]) + 19'(latest);
                        ring[slot] = latest;
                        slot = (slot + 1) % RING_DEPTH;
                    end
                end
                CMD_PERIOD_TICK:
                begin
                    if (period_ticks != '1)
                        period_ticks = period_ticks + 1'b1;
                end
                CMD_SCAN:
                begin
                    if (latest != '0 && !hold && period_ticks >= PCOUNT_W'(average_period))
                    begin
                        period_ticks = '0;
                        average = MV_W'(ring_total / RING_DEPTH);
                        updated = 1'b1;
                    end
                end
                CMD_RELEASE:
                    hold = 0;
                default: ;
            endcase
            r.average_mv = average;
            r.latest_mv = latest;
            r.average_updated = updated;
            r.holding = hold;
            expected_readouts.push_back(r);
        endfunction

        function void check_readout(readout_t got);
            readout_t exp;
            if (expected_readouts.size() == 0)
            begin
                flag($sformatf("result with nothing pending: avg %0d latest %0d upd %0b hold %0b",
                    got.average_mv, got.latest_mv, got.average_updated, got.holding));
                return;
            end
            exp = expected_readouts.pop_front();
            if (got.average_mv !== exp.average_mv)
                flag($sformatf("average_mv expected %0d got %0d", exp.average_mv, got.average_mv));
            if (got.latest_mv !== exp.latest_mv)
                flag($sformatf("latest_mv expected %0d got %0d", exp.latest_mv, got.latest_mv));
            if (got.average_updated !== exp.average_updated)
                flag($sformatf("average_updated expected %0b got %0b",
                    exp.average_updated, got.average_updated));
            if (got.holding !== exp.holding)
                flag($sformatf("holding expected %0b got %0b", exp.holding, got.holding));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [2:0]            command = '0;
    logic [MV_W-1:0]       sample_mv = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [MV_W-1:0]       average_mv;
    logic [MV_W-1:0]       latest_mv;
    logic                  average_updated;
    logic                  holding;

    voltage_average_predictor model;
    bit quiet = 0;
    int out_wait = 0;
    int cycles = 0;

    battery_voltage_moving_average #(
        .HISTORY_DEPTH(RING_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .sample_mv(sample_mv),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .average_mv(average_mv),
        .latest_mv(latest_mv),
        .average_updated(average_updated),
        .holding(holding)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait();
        if (quiet)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // both channels observed with the values present before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                model.take_command(command, sample_mv);
            if (out_valid && !out_stall)
                model.check_readout({average_mv, latest_mv, average_updated, holding});
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            out_wait = draw_wait();
        else if (out_wait > 0)
            out_wait = out_wait - 1;
        out_stall <= (out_wait > 0);
    end

    task automatic send_request(input logic [2:0] cmd, input logic [MV_W-1:0] mv);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        sample_mv <= mv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop in_valid and wait on the clock first so the last accepted request is already in the queue
    task automatic finish_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (model.expected_readouts.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] mask;
        mask = (idx == REG_OFFSET) ? CFG_DATA_W'((1 << OFFSET_W) - 1)
                                   : CFG_DATA_W'((1 << PERIOD_W) - 1);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model.set_register(idx, value);
        // read back through the same port
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== (value & mask))
            model.flag($sformatf("register %0d read expected %0d got %0d",
                idx, value & mask, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int offset, input int buf_period, input int avg_period);
        write_register(REG_OFFSET, offset);
        write_register(REG_BUFFER_PERIOD, buf_period);
        write_register(REG_AVERAGE_PERIOD, avg_period);
    endtask

    task automatic random_requests(input int count);
        int roll;
        int off;
        logic [2:0] cmd;
        logic [MV_W-1:0] mv;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            off = model.offset;
            mv = MV_W'($urandom);
            if (roll < 20)
            begin
                cmd = CMD_SAMPLE;
                case ($urandom_range(0, 5))
                    0: mv = $urandom_range(0, 1) ? '1 : '0;
                    1: mv = MV_W'(off + 1 - $urandom_range(0, (off > 0) ? 2 : 1));
                    2: mv = MV_W'($urandom_range(0, off));
                    default: ;
                endcase
            end
            else if (roll < 45)
                cmd = CMD_BUFFER_TICK;
            else if (roll < 70)
                cmd = CMD_PERIOD_TICK;
            else if (roll < 90)
                cmd = CMD_SCAN;
            else if (roll < 96)
                cmd = CMD_RELEASE;
            else
                cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
            send_request(cmd, mv);
        end
    endtask

    task automatic run_phase(input int offset, input int buf_period, input int avg_period,
                             input int count, input bit no_gaps);
        configure(offset, buf_period, avg_period);
        quiet = no_gaps;
        random_requests(count);
        finish_requests();
    endtask

    initial
    begin
        model = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unused and other codes before a reading, then zero and offset-level readings
        send_request(CMD_FIRST_UNUSED, '1);
        send_request(CMD_FIRST_UNUSED + 3'd1, '0);
        send_request(CMD_LAST_CODE, 16'h5555);
        send_request(CMD_BUFFER_TICK, '0);
        send_request(CMD_PERIOD_TICK, '0);
        send_request(CMD_SCAN, '0);
        send_request(CMD_RELEASE, '0);
        send_request(CMD_SAMPLE, '0);
        send_request(CMD_SCAN, '0);
        send_request(CMD_RELEASE, '0);
        send_request(CMD_SCAN, '0);
        send_request(CMD_SAMPLE, MV_W'(OFFSET_RESET));
        send_request(CMD_SCAN, '0);
        finish_requests();

        // zero periods: every tick writes, every eligible scan recomputes
        configure(1000, 0, 0);
        send_request(CMD_BUFFER_TICK, 16'hAAAA);
        send_request(CMD_SCAN, '0);
        send_request(CMD_SAMPLE, '1);
        send_request(CMD_BUFFER_TICK, '0);
        send_request(CMD_BUFFER_TICK, '0);
        send_request(CMD_PERIOD_TICK, '0);
        send_request(CMD_SCAN, '0);
        send_request(CMD_SAMPLE, 16'd1000);
        send_request(CMD_SAMPLE, 16'd1001);
        send_request(CMD_RELEASE, '0);
        send_request(CMD_SCAN, '0);
        finish_requests();

        run_phase(0, 0, 0, 150, 0);
        run_phase(1000, 1, 1, 150, 0);
        run_phase(1023, 2, 3, 150, 1);
        run_phase(60, 3, 2, 150, 0);
        run_phase(5, 65535, 65535, 100, 0);
        for (int p = 0; p < 3; p++)
            run_phase($urandom_range(0, 1000), $urandom_range(1, 4), $urandom_range(0, 6),
                      100, $urandom_range(0, 3) == 0);

        if (model.expected_readouts.size() != 0)
            model.flag("results still pending at end of run");
        if (model.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
